FILE: hdl/iim_pkg.sv
package iim_pkg;

   localparam int COORD_WIDTH = 32;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_LIST = 1'b1;

   typedef struct packed {
      logic      mode;
      coord_type interval_start;
      coord_type interval_end;
      logic      last_in_list;
   } req_type;

   typedef struct packed {
      coord_type out_start;
      coord_type out_end;
      logic      out_last;
   } rsp_type;

   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } op_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

FILE: hdl/iim_front.sv
module iim_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iim_pkg::req_type req_payload,
   output logic             push_valid,
   input  logic             push_ready,
   output iim_pkg::op_type  push_op
);
   import iim_pkg::*;

   localparam logic [1:0] PH_AFTER   = 2'd0;
   localparam logic [1:0] PH_BEFORE  = 2'd1;
   localparam logic [1:0] PH_MERGING = 2'd2;

   logic [1:0] phase_ff, phase_in;
   coord_type  held_start_ff, held_start_in;
   coord_type  held_end_ff, held_end_in;

   logic      accept;
   logic      emit;
   op_type    op;
   coord_type s, e, ns, ne;
   logic      last;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign s         = req_payload.interval_start;
   assign e         = req_payload.interval_end;
   assign last      = req_payload.last_in_list;
   assign ns        = (s < held_start_ff) ? s : held_start_ff;
   assign ne        = (held_end_ff < e) ? e : held_end_ff;

   always_comb begin
      phase_in      = phase_ff;
      held_start_in = held_start_ff;
      held_end_in   = held_end_ff;
      emit          = 1'b0;
      op            = '0;
      if (req_payload.mode == MODE_LOAD) begin
         held_start_in = s;
         held_end_in   = e;
         if (last) begin
            emit     = 1'b1;
            op.first = '{out_start: s, out_end: e, out_last: 1'b1};
            phase_in = PH_AFTER;
         end else begin
            phase_in = PH_BEFORE;
         end
      end else if (phase_ff != PH_BEFORE && phase_ff != PH_MERGING) begin
         emit     = 1'b1;
         op.first = '{out_start: s, out_end: e, out_last: last};
         phase_in = PH_AFTER;
      end else if (phase_ff == PH_BEFORE && e < held_start_ff) begin
         emit     = 1'b1;
         op.first = '{out_start: s, out_end: e, out_last: 1'b0};
         if (last) begin
            op.two    = 1'b1;
            op.second = '{out_start: held_start_ff, out_end: held_end_ff, out_last: 1'b1};
            phase_in  = PH_AFTER;
         end
      end else if (!(held_end_ff < s)) begin
         held_start_in = ns;
         held_end_in   = ne;
         if (last) begin
            emit     = 1'b1;
            op.first = '{out_start: ns, out_end: ne, out_last: 1'b1};
            phase_in = PH_AFTER;
         end else begin
            phase_in = PH_MERGING;
         end
      end else begin
         emit      = 1'b1;
         op.two    = 1'b1;
         op.first  = '{out_start: held_start_ff, out_end: held_end_ff, out_last: 1'b0};
         op.second = '{out_start: s, out_end: e, out_last: last};
         phase_in  = PH_AFTER;
      end
   end

   assign push_valid = accept && emit;
   assign push_op    = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_AFTER;
         held_start_ff <= '0;
         held_end_ff   <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         held_start_ff <= held_start_in;
         held_end_ff   <= held_end_in;
      end
   end

endmodule

FILE: hdl/iim_queue.sv
module iim_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  iim_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output iim_pkg::op_type pop_op
);
   import iim_pkg::*;

   op_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

FILE: hdl/iim_back.sv
module iim_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  iim_pkg::op_type  pop_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iim_pkg::rsp_type rsp_payload
);
   import iim_pkg::*;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    second_ff;
   logic    load;

   assign load      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = (!rsp_valid_ff || rsp_ready) && (second_ff || !pop_op.two);

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= second_ff ? pop_op.second : pop_op.first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            second_ff    <= pop_op.two && !second_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/interval_insert_merge_unit.sv
// channel   ports                                   direction
// request   req_valid, req_ready, req_payload       in
// response  rsp_valid, rsp_ready, rsp_payload       out
//
// Accepts one request per cycle while queue has room, updating the held interval.
// A request yielding two responses sends both through the output register in turn.
// Two-entry queue between front and back; the front stalls only when it is full.
// A first response is registered in a queue entry, then in the output register.
// Reset clears phase, queue and output valid.
module interval_insert_merge_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iim_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iim_pkg::rsp_type rsp_payload
);
   import iim_pkg::*;

   logic   push_valid, push_ready;
   op_type push_op;
   logic   pop_valid, pop_ready;
   op_type pop_op;

   iim_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_op     (push_op)
   );

   iim_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   iim_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_op      (pop_op),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
